// ===== rtl/xdt_field_deframer_top_assert.svh =====
// assertion macros for the xdt field deframer checker
`ifndef XDT_FIELD_DEFRAMER_TOP_ASSERT_SVH
`define XDT_FIELD_DEFRAMER_TOP_ASSERT_SVH

// property that must hold in the same cycle
`define XDT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// property that must hold in the following cycle
`define XDT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/xdt_pkg.sv =====
// shared types and constants for the xdt field deframer
package xdt_pkg;

  localparam int LENGTH_DIGITS_DEF = 3;
  localparam int CODE_DIGITS_DEF   = 4;
  localparam int QUEUE_DEPTH_DEF   = 4;

  localparam logic [13:0] FIELD_CODE_RESET = 14'd8000;
  localparam logic [9:0]  LEN_MAX          = 10'd999;
  localparam logic [9:0]  FIXED_LEN        = 10'd9;
  localparam logic [13:0] TYPE_MAX         = 14'd9999;
  localparam logic [2:0]  TERM_BYTES       = 3'd2;

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_CODE = 2'd1,
    PH_BODY = 2'd2,
    PH_TERM = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_CONTENT   = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_ERROR     = 2'd2
  } result_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } src_item_t;

  typedef struct packed {
    result_kind_t result_kind;
    logic [13:0]  field_code;
    logic [7:0]   content_byte;
    logic [9:0]   content_index;
    logic [13:0]  record_type;
    logic         last_of_run;
  } res_item_t;

  typedef struct packed {
    result_kind_t kind;
    logic [13:0]  code;
    logic [7:0]   data;
    logic [9:0]   index;
    logic [13:0]  rtype;
    logic         err_after;
  } q_entry_t;

endpackage

// ===== rtl/xdt_queue.sv =====
// request queue between the byte parser and the result emitter
module xdt_queue #(
  parameter int DEPTH = xdt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  xdt_pkg::q_entry_t push_data,
  output logic              full,
  input  logic              pop,
  output xdt_pkg::q_entry_t pop_data,
  output logic              empty
);
  import xdt_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push_ok;
  logic            pop_ok;

  assign full     = count == CW'(DEPTH);
  assign empty    = count == '0;
  assign push_ok  = push && !full;
  assign pop_ok   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push_ok, pop_ok})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/xdt_front.sv =====
// byte parser: field framing state, record type tracking and request generation
module xdt_front #(
  parameter int LENGTH_DIGITS = xdt_pkg::LENGTH_DIGITS_DEF,
  parameter int CODE_DIGITS   = xdt_pkg::CODE_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [13:0]        cfg_data,
  input  logic               src_valid,
  output logic               src_stall,
  input  xdt_pkg::src_item_t src_item,
  input  logic               q_full,
  output logic               q_push,
  output xdt_pkg::q_entry_t  q_entry
);
  import xdt_pkg::*;

  logic [13:0]  record_field_code;

  phase_t       phase, phase_mid, phase_next;
  logic [2:0]   digit_count, count_mid, count_next;
  logic [9:0]   field_length, len_mid, len_next;
  logic [13:0]  current_code, code_mid, code_next;
  logic [9:0]   bytes_left, left_mid, left_next;
  logic [13:0]  type_accumulator, tacc_mid, tacc_next;
  logic [13:0]  record_kind, kind_mid;

  logic         accept;
  logic         is_digit;
  logic [3:0]   digit_val;
  logic [2:0]   count_inc;
  logic [13:0]  len_prod;
  logic [9:0]   len_sat;
  logic [13:0]  code_prod;
  logic [16:0]  type_prod;
  logic [13:0]  type_sat;
  logic [9:0]   body_len;
  logic         typed;
  logic         eoi_err;

  logic         first_valid;
  result_kind_t first_kind;
  logic [13:0]  first_code;
  logic [7:0]   first_data;
  logic [9:0]   first_index;

  assign cfg_ready = 1'b1;
  assign src_stall = q_full;
  assign accept    = src_valid && !q_full;

  assign is_digit  = src_item.data_byte inside {[8'h30:8'h39]};
  assign digit_val = is_digit ? src_item.data_byte[3:0] : 4'd0;
  assign count_inc = digit_count + 3'd1;
  assign len_prod  = {4'd0, field_length} * 14'd10 + {10'd0, digit_val};
  assign len_sat   = (len_prod > 14'd999) ? LEN_MAX : len_prod[9:0];
  assign code_prod = current_code * 14'd10 + {10'd0, digit_val};
  assign type_prod = {3'd0, type_accumulator} * 17'd10 + {13'd0, digit_val};
  assign type_sat  = (type_prod > 17'd9999) ? TYPE_MAX : type_prod[13:0];
  assign body_len  = field_length - FIXED_LEN;
  assign typed     = current_code == record_field_code;

  // next phase
  always_comb begin
    phase_mid = phase;
    case (phase)
      PH_CODE: begin
        if (!is_digit) begin
          phase_mid = PH_LEN;
        end else if (count_inc >= 3'(CODE_DIGITS)) begin
          phase_mid = (body_len != '0) ? PH_BODY : PH_TERM;
        end
      end
      PH_BODY: begin
        if (bytes_left == 10'd1) begin
          phase_mid = PH_TERM;
        end
      end
      PH_TERM: begin
        if (count_inc >= TERM_BYTES) begin
          phase_mid = PH_LEN;
        end
      end
      default: begin
        if (is_digit && count_inc >= 3'(LENGTH_DIGITS) && len_sat >= FIXED_LEN) begin
          phase_mid = PH_CODE;
        end else begin
          phase_mid = PH_LEN;
        end
      end
    endcase
  end

  assign eoi_err    = src_item.end_of_input && (phase_mid != PH_LEN || count_mid != 3'd0);
  assign phase_next = eoi_err ? PH_LEN : phase_mid;

  // field datapath and first request
  always_comb begin
    count_mid   = digit_count;
    len_mid     = field_length;
    code_mid    = current_code;
    left_mid    = bytes_left;
    tacc_mid    = type_accumulator;
    kind_mid    = record_kind;
    first_valid = 1'b0;
    first_kind  = KIND_ERROR;
    first_code  = current_code;
    first_data  = '0;
    first_index = '0;
    case (phase)
      PH_CODE: begin
        if (!is_digit) begin
          first_valid = 1'b1;
          count_mid   = '0;
          len_mid     = '0;
          code_mid    = '0;
          left_mid    = '0;
          tacc_mid    = '0;
        end else begin
          code_mid  = code_prod;
          count_mid = count_inc;
          if (count_inc >= 3'(CODE_DIGITS)) begin
            count_mid = '0;
            left_mid  = body_len;
            tacc_mid  = '0;
          end
        end
      end
      PH_BODY: begin
        first_valid = 1'b1;
        first_kind  = KIND_CONTENT;
        first_data  = src_item.data_byte;
        first_index = body_len - bytes_left;
        if (typed && is_digit) begin
          tacc_mid = type_sat;
        end
        left_mid = bytes_left - 10'd1;
        if (bytes_left == 10'd1) begin
          count_mid = '0;
        end
      end
      PH_TERM: begin
        count_mid = count_inc;
        if (count_inc >= TERM_BYTES) begin
          if (typed) begin
            kind_mid = type_accumulator;
          end
          first_valid = 1'b1;
          first_kind  = KIND_FIELD_END;
          first_index = body_len;
          count_mid   = '0;
          len_mid     = '0;
          code_mid    = '0;
          left_mid    = '0;
          tacc_mid    = '0;
        end
      end
      default: begin
        first_code = '0;
        if (!is_digit) begin
          first_valid = 1'b1;
          count_mid   = '0;
          len_mid     = '0;
          code_mid    = '0;
          left_mid    = '0;
          tacc_mid    = '0;
        end else begin
          len_mid   = len_sat;
          count_mid = count_inc;
          if (count_inc >= 3'(LENGTH_DIGITS)) begin
            count_mid = '0;
            code_mid  = '0;
            if (len_sat < FIXED_LEN) begin
              first_valid = 1'b1;
              len_mid     = '0;
              left_mid    = '0;
              tacc_mid    = '0;
            end
          end
        end
      end
    endcase
  end

  assign count_next = eoi_err ? '0 : count_mid;
  assign len_next   = eoi_err ? '0 : len_mid;
  assign code_next  = eoi_err ? '0 : code_mid;
  assign left_next  = eoi_err ? '0 : left_mid;
  assign tacc_next  = eoi_err ? '0 : tacc_mid;

  assign q_push = accept && (first_valid || eoi_err);

  always_comb begin
    if (first_valid) begin
      q_entry = '{kind: first_kind, code: first_code, data: first_data,
                  index: first_index, rtype: kind_mid, err_after: eoi_err};
    end else begin
      q_entry = '{kind: KIND_ERROR, code: code_mid, data: '0,
                  index: '0, rtype: kind_mid, err_after: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      record_field_code <= FIELD_CODE_RESET;
      phase             <= PH_LEN;
      digit_count       <= '0;
      field_length      <= '0;
      current_code      <= '0;
      bytes_left        <= '0;
      type_accumulator  <= '0;
      record_kind       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        record_field_code <= cfg_data;
      end
      if (accept) begin
        phase            <= phase_next;
        digit_count      <= count_next;
        field_length     <= len_next;
        current_code     <= code_next;
        bytes_left       <= left_next;
        type_accumulator <= tacc_next;
        record_kind      <= kind_mid;
      end
    end
  end

endmodule

// ===== rtl/xdt_back.sv =====
// result emitter: drains requests into the output register, splitting double requests
module xdt_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  xdt_pkg::q_entry_t q_entry,
  output logic              q_pop,
  output logic              res_valid,
  input  logic              res_stall,
  output xdt_pkg::res_item_t res_item
);
  import xdt_pkg::*;

  logic load;
  logic pend_err;

  assign load  = !res_valid || !res_stall;
  assign q_pop = load && !pend_err && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      pend_err  <= 1'b0;
    end else if (load) begin
      if (pend_err) begin
        res_valid <= 1'b1;
        pend_err  <= 1'b0;
      end else if (!q_empty) begin
        res_valid <= 1'b1;
        pend_err  <= q_entry.err_after;
      end else begin
        res_valid <= 1'b0;
      end
    end
  end

  // trailing error keeps the code and record type of the result before it
  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_err) begin
        res_item.result_kind   <= KIND_ERROR;
        res_item.content_byte  <= '0;
        res_item.content_index <= '0;
        res_item.last_of_run   <= 1'b1;
      end else if (!q_empty) begin
        res_item.result_kind   <= q_entry.kind;
        res_item.field_code    <= q_entry.code;
        res_item.content_byte  <= q_entry.data;
        res_item.content_index <= q_entry.index;
        res_item.record_type   <= q_entry.rtype;
        res_item.last_of_run   <= !q_entry.err_after;
      end
    end
  end

endmodule

// ===== rtl/xdt_field_deframer_top.sv =====
// top level of the xdt field deframer
//
// src channel: one stream byte per request (data_byte, end_of_input), taken
// when src_valid is high and src_stall is low. Up to one byte per cycle.
// res channel: result items (content byte, field end, error) with
// last_of_run set on the final result of a byte; taken when res_valid is
// high and res_stall is low. A byte gives zero, one or two results.
// cfg channel: cfg_data written to the record field code on cfg_valid and
// cfg_ready; cfg_ready is always high. Write only while the block is idle.
// Path: the parser writes each request into the request queue, and the
// emitter then loads it into the output register that drives res_item.
// Throughput: one byte per cycle while src_stall is low; a byte with two
// results gives them from the output register one after the other.
// Reset: parser returns to awaiting length digits, record type 0, record
// field code 8000, request queue empty.
// Receiver stall: the output register holds; the parser keeps taking bytes
// until the request queue of QUEUE_DEPTH entries fills, then raises src_stall.
module xdt_field_deframer_top #(
  parameter int LENGTH_DIGITS = xdt_pkg::LENGTH_DIGITS_DEF,
  parameter int CODE_DIGITS   = xdt_pkg::CODE_DIGITS_DEF,
  parameter int QUEUE_DEPTH   = xdt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [13:0]         cfg_data,
  input  logic                src_valid,
  output logic                src_stall,
  input  xdt_pkg::src_item_t  src_item,
  output logic                res_valid,
  input  logic                res_stall,
  output xdt_pkg::res_item_t  res_item
);
  import xdt_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  q_entry_t q_in;
  q_entry_t q_out;

  xdt_front #(
    .LENGTH_DIGITS(LENGTH_DIGITS),
    .CODE_DIGITS  (CODE_DIGITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .src_item (src_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  xdt_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_out),
    .empty    (q_empty)
  );

  xdt_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_entry  (q_out),
    .q_pop    (q_pop),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_item (res_item)
  );

endmodule

// ===== rtl/xdt_checker.sv =====
// port-level assertion checker for the xdt field deframer, bound to the top level
`include "xdt_field_deframer_top_assert.svh"

module xdt_checker (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_stall,
  input xdt_pkg::res_item_t res_item
);
  import xdt_pkg::*;

  `XDT_ASSERT_NEXT(a_res_hold, res_valid && res_stall,
    res_valid && $stable(res_item), "stalled result changed")
  `XDT_ASSERT_NOW(a_byte_zero, res_valid && res_item.result_kind != KIND_CONTENT,
    res_item.content_byte == 8'd0, "content byte set on non-content result")
  `XDT_ASSERT_NOW(a_err_last, res_valid && res_item.result_kind == KIND_ERROR,
    res_item.last_of_run && res_item.content_index == 10'd0, "malformed error result")
  `XDT_ASSERT_NEXT(a_err_follows, res_valid && !res_stall && !res_item.last_of_run,
    res_valid && res_item.result_kind == KIND_ERROR, "non-last result not followed by error")

endmodule

bind xdt_field_deframer_top xdt_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .res_valid(res_valid),
  .res_stall(res_stall),
  .res_item (res_item)
);
